/* rtl/tlb_refill_round_robin_unit_macros.svh */
// Assertion helpers, clocked on clk_i and idle while rst_ni is low.
`ifndef TLB_REFILL_ROUND_ROBIN_UNIT_MACROS_SVH
`define TLB_REFILL_ROUND_ROBIN_UNIT_MACROS_SVH

`define TLBRR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define TLBRR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/tlbrr_pkg.sv */
`default_nettype none

package tlbrr_pkg;

  localparam int unsigned PageW = 20;
  localparam int unsigned SlotW = 6;

  typedef enum logic {
    FUNC_FILL    = 1'b0,
    FUNC_REPLACE = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    OUT_HIT    = 3'd0,
    OUT_FREE   = 3'd1,
    OUT_RR     = 3'd2,
    OUT_VICTIM = 3'd3,
    OUT_ABSENT = 3'd4
  } outcome_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_e;

  typedef struct packed {
    func_e              func;
    logic [PageW-1:0]   fault_page;
    logic [PageW-1:0]   frame;
    logic               is_write;
    logic [PageW-1:0]   victim_page;
  } in_item_t;

  typedef struct packed {
    logic [SlotW-1:0]   slot;
    outcome_e           outcome;
    logic               dirty_set;
  } out_item_t;

  // One stored translation; the valid mark lives in flops beside the memory.
  typedef struct packed {
    logic [PageW-1:0]   page;
    logic [PageW-1:0]   frame;
    logic               dirty;
  } entry_t;

endpackage

`default_nettype wire

/* rtl/tlb_refill_round_robin_unit.sv */
// One item at a time: a new input beat is taken only in the idle state, and the result
// beat is loaded from the decide state. A single probe pass reads the entry
// memory one slot a cycle through its one read port, then the decide state writes back.
// Reset: all valid marks cleared at once and the round-robin pointer set to zero;
// the entry memory itself is not cleared, so the block is ready straight after reset.
`default_nettype none

module tlb_refill_round_robin_unit #(
  parameter int unsigned TLB_SLOTS = 64,
  parameter int unsigned PAGE_BITS = 20
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire tlbrr_pkg::in_item_t   in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output tlbrr_pkg::out_item_t       out_data_o
);

  import tlbrr_pkg::*;

  `include "tlb_refill_round_robin_unit_macros.svh"

  localparam int unsigned IdxW = $clog2(TLB_SLOTS);
  localparam int unsigned CntW = $clog2(TLB_SLOTS + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TLB_SLOTS - 1);
  localparam logic [CntW-1:0] SlotsCnt = CntW'(TLB_SLOTS);
  localparam logic [PageW-1:0] PageMask = (PAGE_BITS >= PageW) ? {PageW{1'b1}} :
                                          PageW'((64'd1 << PAGE_BITS) - 64'd1);

  entry_t tlb_mem [TLB_SLOTS];

  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                chk_vld_q;
  logic [IdxW-1:0]     chk_idx_q;
  entry_t              rd_q;
  in_item_t            item_q;
  logic                hit_found_q, free_found_q;
  logic [IdxW-1:0]     hit_idx_q, free_idx_q;
  logic [IdxW-1:0]     rr_q, rr_d;
  logic [TLB_SLOTS-1:0] valid_q;
  logic                out_valid_q;
  out_item_t           out_q, out_d;

  logic                in_acc;
  in_item_t            in_masked;
  logic                mem_re, mem_we;
  logic [IdxW-1:0]     mem_ra, mem_wa;
  entry_t              mem_wd;
  logic                rr_adv, out_load;
  logic [IdxW-1:0]     tgt_idx;
  logic [IdxW+SlotW-1:0] slot_ext;
  logic [PageW-1:0]    key_page;
  logic                chk_match, chk_hole;

  assign in_acc   = in_valid_i && in_ready_o;
  assign key_page = (item_q.func == FUNC_REPLACE) ? item_q.victim_page : item_q.fault_page;

  always_comb begin
    in_masked             = in_data_i;
    in_masked.fault_page  = in_data_i.fault_page & PageMask;
    in_masked.frame       = in_data_i.frame & PageMask;
    in_masked.victim_page = in_data_i.victim_page & PageMask;
  end

  // Check stage: read data for chk_idx_q is back from the memory this cycle.
  assign chk_match = chk_vld_q && valid_q[chk_idx_q] && (rd_q.page == key_page);
  assign chk_hole  = chk_vld_q && !valid_q[chk_idx_q];

  assign slot_ext = {{SlotW{1'b0}}, tgt_idx};
  assign rr_d     = (rr_q == LastIdx) ? '0 : rr_q + IdxW'(1);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    mem_re     = 1'b0;
    mem_ra     = cnt_q[IdxW-1:0];
    mem_we     = 1'b0;
    mem_wa     = '0;
    mem_wd     = '{page: item_q.fault_page, frame: item_q.frame, dirty: item_q.is_write};
    rr_adv     = 1'b0;
    out_load   = 1'b0;
    tgt_idx    = '0;
    out_d      = '{slot: '0, outcome: OUT_ABSENT, dirty_set: 1'b0};

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_SCAN;
          cnt_d   = '0;
        end
      end
      ST_SCAN: begin
        if (cnt_q < SlotsCnt) begin
          mem_re = 1'b1;
          cnt_d  = cnt_q + CntW'(1);
        end
        if (chk_vld_q && chk_idx_q == LastIdx) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        // Hold the decision until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
          priority if (item_q.func == FUNC_REPLACE) begin
            if (hit_found_q) begin
              mem_we       = 1'b1;
              tgt_idx      = hit_idx_q;
              mem_wd.dirty = 1'b1;
              out_d.outcome = OUT_VICTIM;
            end else begin
              out_d.outcome = OUT_ABSENT;
            end
          end else if (hit_found_q) begin
            mem_we        = 1'b1;
            tgt_idx       = hit_idx_q;
            out_d.outcome = OUT_HIT;
          end else if (free_found_q) begin
            mem_we        = 1'b1;
            tgt_idx       = free_idx_q;
            out_d.outcome = OUT_FREE;
          end else begin
            mem_we        = 1'b1;
            tgt_idx       = rr_q;
            rr_adv        = 1'b1;
            out_d.outcome = OUT_RR;
          end
          mem_wa          = tgt_idx;
          out_d.slot      = mem_we ? slot_ext[SlotW-1:0] : '0;
          out_d.dirty_set = mem_we ? mem_wd.dirty : 1'b0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      chk_vld_q    <= 1'b0;
      hit_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      rr_q         <= '0;
      valid_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      chk_vld_q <= mem_re;
      if (in_acc) begin
        hit_found_q  <= 1'b0;
        free_found_q <= 1'b0;
      end else begin
        // First hit and first hole in slot order win.
        if (chk_match && !hit_found_q) begin
          hit_found_q <= 1'b1;
        end
        if (chk_hole && !free_found_q) begin
          free_found_q <= 1'b1;
        end
      end
      if (rr_adv) begin
        rr_q <= rr_d;
      end
      if (mem_we) begin
        valid_q[mem_wa] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q <= mem_ra;
    if (in_acc) begin
      item_q <= in_masked;
    end
    if (chk_match && !hit_found_q) begin
      hit_idx_q <= chk_idx_q;
    end
    if (chk_hole && !free_found_q) begin
      free_idx_q <= chk_idx_q;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  // Entry memory: one write port, one registered read port. The sequencer
  // never reads and writes in the same cycle, so no forwarding is needed.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tlb_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= tlb_mem[mem_ra];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `TLBRR_ASSERT(a_no_rw_overlap, !(mem_we && mem_re), "memory read and write overlap")
  `TLBRR_ASSERT_IMP(a_rr_only_when_full, rr_adv, &valid_q, "round-robin pick with a free slot")
  `TLBRR_ASSERT_IMP(a_rr_moves_on_pick, rr_q != $past(rr_q), $past(rr_adv),
                    "round-robin pointer moved without a pick")
  `TLBRR_ASSERT_IMP(a_absent_is_empty, out_valid_o && out_data_o.outcome == OUT_ABSENT,
                    out_data_o.slot == '0 && !out_data_o.dirty_set,
                    "absent victim result carries a slot or dirty mark")

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`default_nettype none

module tb_top;
  import tlbrr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOTS    = 64;
  localparam int POOL      = 128;
  localparam int N_RAND_A  = 500;
  localparam int N_RAND_B  = 500;
  localparam int N_RAND_C  = 336;
  localparam int HOLD_AT   = 640;
  localparam int HOLD_LEN  = 400;
  localparam int LIMIT     = 1000000;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      in_ready;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  tlb_refill_round_robin_unit #(
    .TLB_SLOTS(NSLOTS),
    .PAGE_BITS(PageW)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #5 clk_i = ~clk_i;

  // shadow TLB: only page and valid mark are visible through the results
  logic [PageW-1:0] tlb_page [NSLOTS];
  bit               tlb_valid[NSLOTS];
  int               rr_next = 0;

  in_item_t         pending_refills[$];
  out_item_t        expected_writes[$];
  logic [PageW-1:0] page_pool[POOL];

  bit  in_beat    = 1'b0;
  bit  calm       = 1'b0;
  int  n_in_beats = 0;
  int  n_checked  = 0;
  int  n_fail     = 0;
  int  n_cycles   = 0;
  int  outcome_seen[5];

  function automatic out_item_t predict_refill(input in_item_t it);
    out_item_t        r;
    int               idx;
    int               i;
    logic [PageW-1:0] key;
    r   = '0;
    idx = -1;
    key = (it.func == FUNC_REPLACE) ? it.victim_page : it.fault_page;
    // lowest valid match wins when a page sits in more than one slot
    for (i = 0; i < NSLOTS; i++)
      if (idx < 0 && tlb_valid[i] && tlb_page[i] == key) idx = i;
    if (it.func == FUNC_REPLACE) begin
      r.outcome   = (idx < 0) ? OUT_ABSENT : OUT_VICTIM;
      r.dirty_set = (idx >= 0);
    end else if (idx >= 0) begin
      r.outcome   = OUT_HIT;
      r.dirty_set = it.is_write;
    end else begin
      for (i = 0; i < NSLOTS; i++)
        if (idx < 0 && !tlb_valid[i]) idx = i;
      if (idx >= 0) begin
        r.outcome = OUT_FREE;
      end else begin
        idx       = rr_next;
        rr_next   = (rr_next + 1) % NSLOTS;
        r.outcome = OUT_RR;
      end
      r.dirty_set = it.is_write;
    end
    if (r.outcome != OUT_ABSENT) begin
      tlb_page[idx]  = it.fault_page;
      tlb_valid[idx] = 1'b1;
      r.slot         = idx[SlotW-1:0];
    end
    return r;
  endfunction

  function automatic in_item_t make_item(input func_e f, input logic [PageW-1:0] fpage,
                                         input logic [PageW-1:0] frm, input logic wr,
                                         input logic [PageW-1:0] vpage);
    in_item_t it;
    it.func        = f;
    it.fault_page  = fpage;
    it.frame       = frm;
    it.is_write    = wr;
    it.victim_page = vpage;
    return it;
  endfunction

  // mostly pages from a pool larger than the TLB, so hits, misses and victims all occur
  function automatic in_item_t random_refill();
    in_item_t it;
    it.func        = ($urandom_range(0, 3) == 0) ? FUNC_REPLACE : FUNC_FILL;
    it.fault_page  = ($urandom_range(0, 6) != 0) ? page_pool[$urandom_range(0, POOL-1)]
                                                 : PageW'($urandom);
    it.frame       = PageW'($urandom);
    it.is_write    = 1'($urandom_range(0, 1));
    it.victim_page = ($urandom_range(0, 4) != 0) ? page_pool[$urandom_range(0, POOL-1)]
                                                 : PageW'($urandom);
    return it;
  endfunction

  // input side: hold the beat until taken, then maybe idle, then offer the next
  always @(negedge clk_i) begin : drive_in
    logic     v;
    in_item_t d;
    int       src_gap;
    v = in_valid;
    d = in_data;
    if (!rst_ni) begin
      v       = 1'b0;
      src_gap = 0;
    end else if (!(in_valid && !in_beat)) begin
      v = 1'b0;
      if (src_gap > 0) begin
        src_gap--;
      end else if (pending_refills.size() != 0) begin
        d = pending_refills.pop_front();
        v = 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 17);
      end
    end
    in_valid <= v;
    in_data  <= d;
  end

  // output side: random stalls, plus one long hold-off that backs the block up
  always @(negedge clk_i) begin : drive_out
    logic r;
    int   snk_gap;
    int   hold_cnt;
    bit   hold_done;
    r = 1'b1;
    if (!rst_ni) begin
      r         = 1'b0;
      snk_gap   = 0;
      hold_cnt  = 0;
      hold_done = 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      r = 1'b0;
    end else if (!hold_done && n_in_beats >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_cnt  = HOLD_LEN - 1;
      r         = 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap--;
      r = 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      snk_gap = $urandom_range(1, 17) - 1;
      r       = 1'b0;
    end
    out_ready <= r;
  end

  always @(posedge clk_i) begin : watch
    out_item_t want;
    in_beat <= rst_ni && in_valid && in_ready;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_writes.size() == 0) begin
        $error("result beat with nothing expected: slot %0d outcome %0d dirty_set %0d",
               out_data.slot, out_data.outcome, out_data.dirty_set);
        n_fail++;
      end else begin
        want = expected_writes.pop_front();
        if (out_data.slot !== want.slot) begin
          $error("slot mismatch: expected %0d, got %0d", want.slot, out_data.slot);
          n_fail++;
        end
        if (out_data.outcome !== want.outcome) begin
          $error("outcome mismatch: expected %0d, got %0d", want.outcome, out_data.outcome);
          n_fail++;
        end
        if (out_data.dirty_set !== want.dirty_set) begin
          $error("dirty_set mismatch: expected %0d, got %0d",
                 want.dirty_set, out_data.dirty_set);
          n_fail++;
        end
        if (want.outcome <= OUT_ABSENT) outcome_seen[want.outcome]++;
        n_checked++;
      end
    end
    if (rst_ni && in_valid && in_ready) begin
      expected_writes.push_back(predict_refill(in_data));
      n_in_beats <= n_in_beats + 1;
    end
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= LIMIT) begin
      $display("timed out after %0d cycles, %0d results outstanding",
               n_cycles, expected_writes.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_refills.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_writes.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int i;
    for (i = 0; i < POOL; i++) page_pool[i] = PageW'($urandom);
    page_pool[0] = '0;
    page_pool[1] = '1;

    // directed: extremes, hits, dirty overwrite, absent victim, duplicate pages
    pending_refills.push_back(make_item(FUNC_FILL,    20'h00000, 20'h00000, 1'b0, 20'h00000));
    pending_refills.push_back(make_item(FUNC_FILL,    20'hFFFFF, 20'hFFFFF, 1'b1, 20'hFFFFF));
    pending_refills.push_back(make_item(FUNC_FILL,    20'h00000, 20'hFFFFF, 1'b1, 20'hFFFFF));
    pending_refills.push_back(make_item(FUNC_FILL,    20'hFFFFF, 20'h00000, 1'b0, 20'h00000));
    pending_refills.push_back(make_item(FUNC_REPLACE, 20'hAAAAA, 20'h55555, 1'b1, 20'h55555));
    // victim rewritten with a page already held: page 0 now sits in slots 0 and 1
    pending_refills.push_back(make_item(FUNC_REPLACE, 20'h00000, 20'h12345, 1'b0, 20'hFFFFF));
    pending_refills.push_back(make_item(FUNC_FILL,    20'h00000, 20'h0F0F0, 1'b0, 20'h00000));
    pending_refills.push_back(make_item(FUNC_REPLACE, 20'hFFFFF, 20'hFFFFF, 1'b0, 20'h00000));
    pending_refills.push_back(make_item(FUNC_REPLACE, 20'h54321, 20'h00000, 1'b1, 20'h00000));
    pending_refills.push_back(make_item(FUNC_FILL,    20'hAAAAA, 20'h55555, 1'b1, 20'hAAAAA));
    pending_refills.push_back(make_item(FUNC_FILL,    20'h55555, 20'hAAAAA, 1'b0, 20'h55555));
    pending_refills.push_back(make_item(FUNC_REPLACE, 20'h80000, 20'h00001, 1'b0, 20'h00000));
    pending_refills.push_back(make_item(FUNC_FILL,    20'h00000, 20'h80000, 1'b1, 20'hFFFFF));
    pending_refills.push_back(make_item(FUNC_REPLACE, 20'h00001, 20'hFFFFF, 1'b1, 20'hFFFFF));
    pending_refills.push_back(make_item(FUNC_FILL,    20'h00001, 20'h7FFFF, 1'b0, 20'h80000));

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait_drained();
    for (i = 0; i < N_RAND_A; i++) pending_refills.push_back(random_refill());
    // sender pauses here until every result is back
    wait_drained();
    for (i = 0; i < N_RAND_B; i++) pending_refills.push_back(random_refill());
    wait_drained();
    calm = 1'b1;
    for (i = 0; i < N_RAND_C; i++) pending_refills.push_back(random_refill());
    wait_drained();
    repeat (NSLOTS + 3) @(posedge clk_i);

    $display("%0d results checked: %0d hit, %0d free, %0d round-robin, %0d victim, %0d absent",
             n_checked, outcome_seen[OUT_HIT], outcome_seen[OUT_FREE], outcome_seen[OUT_RR],
             outcome_seen[OUT_VICTIM], outcome_seen[OUT_ABSENT]);
    $display("random stalls on both sides, one %0d-cycle output hold-off, %0d mismatches",
             HOLD_LEN, n_fail);
    if (n_fail == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
